// ----- sv/utt_pkg.sv -----
// types, constants and byte classification shared by the transcoder modules
package utt_pkg;

  localparam logic [15:0] ReplUnit   = 16'hFFFD;
  localparam logic [20:0] ScalarMax  = 21'h10FFFF;
  localparam logic [20:0] SuppBase   = 21'h010000;
  localparam logic [15:0] HiSurrBase = 16'hD800;
  localparam logic [15:0] LoSurrBase = 16'hDC00;
  localparam logic [15:0] SurrFirst  = 16'hD800;
  localparam logic [15:0] SurrLast   = 16'hDFFF;
  localparam logic [15:0] Min3Byte   = 16'h0800;
  localparam logic [10:0] Min2Byte   = 11'h080;

  // one classified byte as held by the decoder
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] need;   // sequence length of a lead, 0 for an invalid lead
    logic       cont;   // byte has the form 10xxxxxx
  } utt_byte_t;

  // one queue entry between front and back
  typedef struct packed {
    utt_byte_t  b;
    logic       last;
  } utt_entry_t;

  // sequence length announced by a lead byte
  function automatic logic [2:0] lead_need(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b[7] == 1'b0) begin
      n = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

// ----- sv/utt_if.sv -----
// stream channels for incoming bytes and outgoing utf-16 units
interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface utt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        out_last;
  modport source (output valid, out_unit, out_last, input ready);
  modport sink   (input valid, out_unit, out_last, output ready);
endinterface

// ----- sv/utf8_to_utf16_transcoder.sv -----
// top level of the utf-8 to utf-16 transcoder
//
//   channel   dir   payload                  handshake
//   byte_i    in    in_byte[7:0], in_last    valid / ready
//   unit_o    out   out_unit[15:0], out_last valid / ready
//
// one byte per cycle is taken while the queue has room; the decoder takes at
// most one byte per cycle from the queue and retires at most one sequence,
// and waits while the output is stalled or a low surrogate is pending. each
// extra unit (low surrogate, replacement for a dropped lead) delays the next byte taken from the queue.
// reset is asynchronous active low and empties the queue and held bytes.
// either side may stall at any time: the queue and output register absorb it.
module utf8_to_utf16_transcoder
  import utt_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  utt_in_if.sink     byte_i,
  utt_out_if.source  unit_o
);

  logic       push, full, pop, head_valid;
  utt_entry_t push_entry, head;

  // byte intake and classification
  utt_front u_front (
    .byte_i  (byte_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // decoupling queue
  utt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // sequence decoder and unit output
  utt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .unit_o       (unit_o)
  );

endmodule

// ----- sv/utt_front.sv -----
// front end: accepts bytes and classifies them into queue entries
module utt_front
  import utt_pkg::*;
(
  utt_in_if.sink     byte_i,
  input  logic       full_i,
  output logic       push_o,
  output utt_entry_t entry_o
);

  // accept whenever the queue has room
  assign byte_i.ready = !full_i;
  assign push_o       = byte_i.valid && !full_i;

  // classify the byte as lead and as continuation
  always_comb begin
    entry_o.b.data = byte_i.in_byte;
    entry_o.b.need = lead_need(byte_i.in_byte);
    entry_o.b.cont = (byte_i.in_byte[7:6] == 2'b10);
    entry_o.last   = byte_i.in_last;
  end

endmodule

// ----- sv/utt_queue.sv -----
// small fifo of classified bytes between front and back
module utt_queue
  import utt_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  utt_entry_t push_entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output utt_entry_t head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  utt_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- sv/utt_back.sv -----
// back end: decodes held bytes one sequence at a time and emits utf-16 units
module utt_back
  import utt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  utt_entry_t  head_i,
  output logic        pop_o,
  utt_out_if.source   unit_o
);

  utt_byte_t   buf_q [4];
  utt_byte_t   vbuf  [4];
  utt_byte_t   nbuf  [4];
  logic [2:0]  cnt_q, vlen, cnt_next, consume;
  logic        last_q, vlast;
  logic        active_q;
  logic        have_work, fire, hold, emit, out_free;
  logic [20:0] cp;
  logic [19:0] sv;
  logic [10:0] v2;
  logic [15:0] v3;
  logic [20:0] v4;
  logic [2:0]  need0;
  logic        out_valid_q, out_last_q;
  logic [15:0] out_unit_q;
  logic        lo_pend_q, lo_last_q;
  logic [15:0] lo_unit_q;

  // working view: held bytes plus the queue head when a new byte is taken
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vbuf[i] = buf_q[i];
    end
    vlen  = cnt_q;
    vlast = last_q;
    if (!active_q) begin
      vbuf[cnt_q[1:0]] = head_i.b;
      vlen             = cnt_q + 3'd1;
      vlast            = head_i.last;
    end
  end

  assign have_work = active_q || head_valid_i;
  assign out_free  = !out_valid_q || unit_o.ready;
  assign fire      = have_work && !lo_pend_q && out_free;
  assign pop_o     = fire && !active_q;
  assign emit      = fire && !hold;

  // candidate scalars of each length
  assign v2    = {vbuf[0].data[4:0], vbuf[1].data[5:0]};
  assign v3    = {vbuf[0].data[3:0], vbuf[1].data[5:0], vbuf[2].data[5:0]};
  assign v4    = {vbuf[0].data[2:0], vbuf[1].data[5:0], vbuf[2].data[5:0],
                  vbuf[3].data[5:0]};
  assign need0 = vbuf[0].need;

  // decode one sequence at the front of the working view
  always_comb begin
    hold    = 1'b0;
    consume = 3'd1;
    cp      = {5'd0, ReplUnit};
    if (need0 == 3'd1) begin
      cp = {13'd0, vbuf[0].data};
    end else if (need0 != 3'd0) begin
      if (need0 > vlen) begin
        // incomplete sequence: wait for more, or drop all at end of stream
        if (!vlast) begin
          hold = 1'b1;
        end else begin
          consume = vlen;
        end
      end else begin
        case (need0)
          3'd2: begin
            if (vbuf[1].cont) begin
              consume = 3'd2;
              if (v2 >= Min2Byte) begin
                cp = {10'd0, v2};
              end
            end
          end
          3'd3: begin
            if (vbuf[1].cont && vbuf[2].cont) begin
              consume = 3'd3;
              if (v3 >= Min3Byte && !(v3 >= SurrFirst && v3 <= SurrLast)) begin
                cp = {5'd0, v3};
              end
            end
          end
          3'd4: begin
            if (vbuf[1].cont && vbuf[2].cont && vbuf[3].cont) begin
              consume = 3'd4;
              if (v4 >= SuppBase && v4 <= ScalarMax) begin
                cp = v4;
              end
            end
          end
          default: begin
            consume = 3'd1;
          end
        endcase
      end
    end
  end

  // remaining bytes after this sequence
  always_comb begin
    logic [2:0] sidx;
    cnt_next = vlen - consume;
    for (int i = 0; i < 4; i++) begin
      sidx    = 3'(i) + consume;
      nbuf[i] = vbuf[i];
      if (sidx < 3'd4) begin
        nbuf[i] = vbuf[sidx[1:0]];
      end
    end
  end

  assign sv = 20'(cp - SuppBase);

  // decoder control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
    end else if (fire) begin
      last_q <= vlast;
      if (hold) begin
        cnt_q    <= vlen;
        active_q <= 1'b0;
      end else begin
        cnt_q    <= cnt_next;
        active_q <= (cnt_next != 3'd0);
      end
    end
  end

  // held byte storage
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < 4; i++) begin
        buf_q[i] <= hold ? vbuf[i] : nbuf[i];
      end
    end
  end

  // output register and pending low surrogate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lo_pend_q   <= 1'b0;
    end else begin
      if (lo_pend_q && out_free) begin
        out_valid_q <= 1'b1;
        lo_pend_q   <= 1'b0;
      end else if (emit) begin
        out_valid_q <= 1'b1;
        lo_pend_q   <= (cp >= SuppBase);
      end else if (unit_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (lo_pend_q && out_free) begin
      out_unit_q <= lo_unit_q;
      out_last_q <= lo_last_q;
    end else if (emit) begin
      if (cp >= SuppBase) begin
        out_unit_q <= HiSurrBase + {6'd0, sv[19:10]};
        out_last_q <= 1'b0;
        lo_unit_q  <= LoSurrBase + {6'd0, sv[9:0]};
        lo_last_q  <= vlast && (cnt_next == 3'd0);
      end else begin
        out_unit_q <= cp[15:0];
        out_last_q <= vlast && (cnt_next == 3'd0);
      end
    end
  end

  assign unit_o.valid    = out_valid_q;
  assign unit_o.out_unit = out_unit_q;
  assign unit_o.out_last = out_last_q;

endmodule
